FILE: rtl/segment_address_translator_macros.svh
// ----------------------------------------------------------------------------
// segment_address_translator_macros
// Assertion helpers for the segment address translator.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ADDRESS_TRANSLATOR_MACROS_SVH
`define SEGMENT_ADDRESS_TRANSLATOR_MACROS_SVH

`ifndef SYNTHESIS
`define SAT_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SAT_ASSERT(lbl, prop, msg) \
    `SAT_ASSERT_IMPL(lbl, i_clk, i_rst_n, prop, msg)
`else
`define SAT_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define SAT_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Types, constants and helpers shared by the segment address translator.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int TABLE_SLOTS   = 16;
    localparam int ADDR_BITS     = 32;
    localparam int SLOT_BITS     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    // field widths of the channels
    localparam int SLOT_FIELD_BITS = 4;
    localparam int ID_BITS         = 16;
    localparam int BASE_BITS       = 32;
    localparam int SIZE_BITS       = 16;
    localparam int LA_BITS         = 32;
    localparam int SEGNUM_BITS     = 32;
    localparam int OFFSET_BITS     = 16;
    localparam int STATUS_BITS     = 2;
    localparam int DIVISOR_BITS    = 16;
    localparam logic [DIVISOR_BITS-1:0] MAX_SIZE_RESET = DIVISOR_BITS'(64);

    localparam int DIV_CNT_BITS  = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;

    localparam int Q_DEPTH       = 2;
    localparam int QPTR_BITS     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_XLATE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CLS_4B        = 2'd0,
        CLS_8B        = 2'd1,
        CLS_16B       = 2'd2,
        CLS_UNCHECKED = 2'd3
    } t_class;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_NOSEG  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                        op;
        logic [SLOT_FIELD_BITS-1:0] slot;
        logic                       entry_valid;
        logic [ID_BITS-1:0]         id;
        logic [BASE_BITS-1:0]       base;
        logic [SIZE_BITS-1:0]       size;
        logic [LA_BITS-1:0]         addr;
        t_class                     cls;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q2b;

    localparam int BYTES_BITS = 5;

    function automatic logic [BYTES_BITS-1:0] class_bytes(input t_class cls);
        logic [BYTES_BITS-1:0] r;
        unique case (cls)
            CLS_4B:  r = BYTES_BITS'(4);
            CLS_8B:  r = BYTES_BITS'(8);
            CLS_16B: r = BYTES_BITS'(16);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/sat_req_if.sv
// ----------------------------------------------------------------------------
// sat_req_if
// Request channel: table writes and address translations.
// ----------------------------------------------------------------------------
interface sat_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [sat_pkg::SLOT_FIELD_BITS-1:0] entry_slot;
    logic                                entry_valid;
    logic [sat_pkg::ID_BITS-1:0]         entry_segment_id;
    logic [sat_pkg::BASE_BITS-1:0]       entry_base;
    logic [sat_pkg::SIZE_BITS-1:0]       entry_size;
    logic [sat_pkg::LA_BITS-1:0]         logical_address;
    logic [1:0]                          access_class;

    modport source (
        output valid, kind, entry_slot, entry_valid, entry_segment_id,
               entry_base, entry_size, logical_address, access_class,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_slot, entry_valid, entry_segment_id,
               entry_base, entry_size, logical_address, access_class,
        output ready
    );
endinterface

FILE: rtl/sat_rsp_if.sv
// ----------------------------------------------------------------------------
// sat_rsp_if
// Response channel: translated address and status.
// ----------------------------------------------------------------------------
interface sat_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sat_pkg::BASE_BITS-1:0]   physical_address;
    logic [sat_pkg::SEGNUM_BITS-1:0] segment_number;
    logic [sat_pkg::OFFSET_BITS-1:0] segment_offset;
    logic [sat_pkg::STATUS_BITS-1:0] status;

    modport source (
        output valid, physical_address, segment_number, segment_offset, status,
        input  ready
    );
    modport sink (
        input  valid, physical_address, segment_number, segment_offset, status,
        output ready
    );
endinterface

FILE: rtl/sat_cfg_if.sv
// ----------------------------------------------------------------------------
// sat_cfg_if
// Configuration write channel for the maximum segment size.
// ----------------------------------------------------------------------------
interface sat_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sat_pkg::DIVISOR_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/segment_address_translator.sv
// ----------------------------------------------------------------------------
// segment_address_translator
// Segment table with logical to physical address translation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_req     in   valid / ready   kind, entry_*, logical_address, access_class
//  o_rsp     out  valid / ready   physical_address, segment_number,
//                                 segment_offset, status
//  i_cfg     in   valid / ready   data (max segment size)
//
// a table write goes from the dequeue straight to the result register; a
// translation dequeues, runs the bit-serial divider, walks the slots until a
// match or the last slot, then loads the result register once it is free.
// a two-request queue lets requests land while the back end is busy or stalled.
// reset is synchronous and active low; it empties the table and sets the
// segment size to 64.
`include "segment_address_translator_macros.svh"

module segment_address_translator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sat_req_if.sink   i_req,
    sat_rsp_if.source o_rsp,
    sat_cfg_if.sink   i_cfg
);
    import sat_pkg::*;

    logic [DIVISOR_BITS-1:0] r_max_size;
    logic [DIVISOR_BITS-1:0] w_divisor;
    t_q2b                    w_q;
    logic                    w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_size <= i_cfg.data;
        end
    end

    // a zero size divides by one
    assign w_divisor = (r_max_size == '0) ? DIVISOR_BITS'(1) : r_max_size;

    sat_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_q     (w_q),
        .i_pop   (w_pop)
    );

    sat_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q       (w_q),
        .o_pop     (w_pop),
        .i_divisor (w_divisor),
        .o_rsp     (o_rsp)
    );

    `SAT_ASSERT(a_divisor_nonzero, w_divisor != '0, "zero divisor")
    `SAT_ASSERT(a_pop_needs_request, w_pop |-> w_q.valid, "dequeue from empty queue")
    `SAT_ASSERT(a_cfg_taken, i_cfg.valid |=> r_max_size == $past(i_cfg.data), "config write lost")

endmodule

FILE: rtl/sat_front.sv
// ----------------------------------------------------------------------------
// sat_front
// Accepts requests, decodes the kind and queues them for the back end.
// ----------------------------------------------------------------------------
`include "segment_address_translator_macros.svh"

module sat_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sat_req_if.sink       i_req,
    output sat_pkg::t_q2b o_q,
    input  logic          i_pop
);
    import sat_pkg::*;

    t_cmd                 r_q [Q_DEPTH];
    logic [QPTR_BITS-1:0] r_wp;
    logic [QPTR_BITS-1:0] r_rp;
    logic [QCNT_BITS-1:0] r_count;
    logic                 w_push;
    logic                 w_pop;
    t_cmd                 w_cmd;

    assign i_req.ready = (r_count != QCNT_BITS'(Q_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_pop && (r_count != '0);

    always_comb begin
        w_cmd.op          = i_req.kind ? OP_XLATE : OP_WRITE;
        w_cmd.slot        = i_req.entry_slot;
        w_cmd.entry_valid = i_req.entry_valid;
        w_cmd.id          = i_req.entry_segment_id;
        w_cmd.base        = i_req.entry_base;
        w_cmd.size        = i_req.entry_size;
        w_cmd.addr        = i_req.logical_address;
        w_cmd.cls         = t_class'(i_req.access_class);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.cmd   = r_q[r_rp];

    `SAT_ASSERT(a_count_bound, r_count <= QCNT_BITS'(Q_DEPTH), "queue count above depth")
    `SAT_ASSERT(a_count_up, w_push && !w_pop |=> r_count == $past(r_count) + 1'b1, "lost push")
    `SAT_ASSERT(a_ptr_sync, r_count == '0 |-> r_wp == r_rp, "pointers apart on empty queue")

endmodule

FILE: rtl/sat_div.sv
// ----------------------------------------------------------------------------
// sat_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "segment_address_translator_macros.svh"

module sat_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [sat_pkg::ADDR_BITS-1:0]       i_dividend,
    input  logic [sat_pkg::DIVISOR_BITS-1:0]    i_divisor,
    output logic                                o_done,
    output logic [sat_pkg::ADDR_BITS-1:0]       o_quotient,
    output logic [sat_pkg::DIVISOR_BITS-1:0]    o_remainder
);
    import sat_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [ADDR_BITS-1:0]    r_quo;
    logic [DIVISOR_BITS-1:0] r_rem;
    logic [DIVISOR_BITS-1:0] r_div;
    logic [DIVISOR_BITS:0]   w_trial;
    logic [DIVISOR_BITS+1:0] w_diff;
    logic                    w_borrow;

    assign w_trial  = {r_rem, r_quo[ADDR_BITS-1]};
    assign w_diff   = {1'b0, w_trial} - {2'b00, r_div};
    assign w_borrow = w_diff[DIVISOR_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(ADDR_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_BITS-2:0], ~w_borrow};
            // remainder stays below the divisor, so the trial fits one extra bit
            r_rem <= w_borrow ? w_trial[DIVISOR_BITS-1:0] : w_diff[DIVISOR_BITS-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `SAT_ASSERT(a_rem_below_div, r_done |-> r_rem < r_div, "remainder not below divisor")
    `SAT_ASSERT(a_no_restart, i_start |-> !r_busy, "divider started while busy")
    `SAT_ASSERT(a_done_idle, r_done |-> !r_busy, "done while still busy")

endmodule

FILE: rtl/sat_back.sv
// ----------------------------------------------------------------------------
// sat_back
// Executes queued requests: table writes, divide, slot search, result register.
// ----------------------------------------------------------------------------
`include "segment_address_translator_macros.svh"

module sat_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sat_pkg::t_q2b                    i_q,
    output logic                             o_pop,
    input  logic [sat_pkg::DIVISOR_BITS-1:0] i_divisor,
    sat_rsp_if.source                        o_rsp
);
    import sat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SRCH,
        S_DONE
    } t_state;

    // segment table
    logic                 r_slot_valid [TABLE_SLOTS];
    logic [ID_BITS-1:0]   r_slot_id    [TABLE_SLOTS];
    logic [BASE_BITS-1:0] r_slot_base  [TABLE_SLOTS];
    logic [SIZE_BITS-1:0] r_slot_size  [TABLE_SLOTS];

    t_state                  r_state;
    logic [SLOT_BITS-1:0]    r_idx;
    logic                    r_is_write;
    logic                    r_found;
    t_class                  r_cls;
    logic [ADDR_BITS-1:0]    r_segnum;
    logic [OFFSET_BITS-1:0]  r_offset;
    logic [BASE_BITS-1:0]    r_hit_base;
    logic [SIZE_BITS-1:0]    r_hit_size;

    logic                    r_out_valid;
    logic [BASE_BITS-1:0]    r_out_phys;
    logic [SEGNUM_BITS-1:0]  r_out_segnum;
    logic [OFFSET_BITS-1:0]  r_out_offset;
    t_status                 r_out_status;

    logic                    w_div_start;
    logic                    w_div_done;
    logic [ADDR_BITS-1:0]    w_quo;
    logic [DIVISOR_BITS-1:0] w_rem;
    logic                    w_match;
    logic                    w_out_free;
    logic                    w_tbl_we;
    logic [BASE_BITS-1:0]    w_phys;
    logic [SIZE_BITS:0]      w_end;
    t_status                 w_status;

    sat_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (ADDR_BITS'(i_q.cmd.addr)),
        .i_divisor   (i_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign o_pop       = (r_state == S_IDLE) && i_q.valid;
    assign w_div_start = o_pop && (i_q.cmd.op == OP_XLATE);
    assign w_tbl_we    = o_pop && (i_q.cmd.op == OP_WRITE) &&
                         (32'(i_q.cmd.slot) < TABLE_SLOTS);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // numbers wider than an id never match
    assign w_match = r_slot_valid[r_idx] &&
                     ({{ADDR_BITS{1'b0}}, r_slot_id[r_idx]} == {{ID_BITS{1'b0}}, r_segnum});

    always_comb begin
        w_phys = r_found ? (r_hit_base + BASE_BITS'(r_offset)) : '0;
        w_end  = (SIZE_BITS+1)'(r_offset) + (SIZE_BITS+1)'(class_bytes(r_cls));
        if (r_is_write) begin
            w_status = ST_OK;
        end else if (!r_found) begin
            w_status = ST_NOSEG;
        end else if (r_cls != CLS_UNCHECKED && w_end > {1'b0, r_hit_size}) begin
            w_status = ST_BOUNDS;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else if (w_tbl_we) begin
            r_slot_valid[SLOT_BITS'(i_q.cmd.slot)] <= i_q.cmd.entry_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_slot_id[SLOT_BITS'(i_q.cmd.slot)]   <= i_q.cmd.id;
            r_slot_base[SLOT_BITS'(i_q.cmd.slot)] <= i_q.cmd.base;
            r_slot_size[SLOT_BITS'(i_q.cmd.slot)] <= i_q.cmd.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // in S_DONE the result register is reloaded below instead
            if (r_out_valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q.valid) begin
                        r_is_write <= (i_q.cmd.op == OP_WRITE);
                        r_found    <= 1'b0;
                        r_cls      <= i_q.cmd.cls;
                        r_segnum   <= '0;
                        r_offset   <= '0;
                        r_state    <= (i_q.cmd.op == OP_WRITE) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_segnum <= w_quo;
                        r_offset <= OFFSET_BITS'(w_rem);
                        r_idx    <= '0;
                        r_state  <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (w_match) begin
                        r_found    <= 1'b1;
                        r_hit_base <= r_slot_base[r_idx];
                        r_hit_size <= r_slot_size[r_idx];
                        r_state    <= S_DONE;
                    end else if (r_idx == SLOT_BITS'(TABLE_SLOTS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_phys   <= w_phys;
                        r_out_segnum <= SEGNUM_BITS'(r_segnum);
                        r_out_offset <= r_offset;
                        r_out_status <= w_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.physical_address = r_out_phys;
    assign o_rsp.segment_number   = r_out_segnum;
    assign o_rsp.segment_offset   = r_out_offset;
    assign o_rsp.status           = r_out_status;

    `SAT_ASSERT(a_noseg_zero, r_out_valid && r_out_status == ST_NOSEG |-> r_out_phys == '0, "address on a miss")
    `SAT_ASSERT(a_div_to_srch, r_state == S_DIV && w_div_done |=> r_state == S_SRCH, "search skipped")
    `SAT_ASSERT(a_offset_range, r_out_valid |-> r_out_offset < i_divisor, "offset not below divisor")
    `SAT_ASSERT(a_found_hit, r_state == S_DONE && r_found |-> !r_is_write, "hit flagged on a table write")

endmodule

FILE: verif/segment_address_translator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_address_translator_checker
// Watches the request, configuration and response channels, keeps its own
// segment table and divisor, predicts every response and compares it field
// by field with what the translator returns.
// ----------------------------------------------------------------------------
module segment_address_translator_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sat_req_if   i_req,
    sat_rsp_if   i_rsp,
    sat_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_xlates,
    output int   o_faults,
    output int   o_misses
);
    import sat_pkg::*;

    typedef struct packed {
        logic [BASE_BITS-1:0]   phys;
        logic [SEGNUM_BITS-1:0] seg_num;
        logic [OFFSET_BITS-1:0] offset;
        t_status                status;
    } t_xlate;

    logic                    seg_used [TABLE_SLOTS];
    logic [ID_BITS-1:0]      seg_id   [TABLE_SLOTS];
    logic [BASE_BITS-1:0]    seg_base [TABLE_SLOTS];
    logic [SIZE_BITS-1:0]    seg_len  [TABLE_SLOTS];
    logic [DIVISOR_BITS-1:0] seg_divisor;

    t_xlate pending_xlates [$];
    int     fail_count;
    int     waiting;
    int     xlate_count;
    int     fault_count;
    int     miss_count;

    assign o_fail_count  = fail_count;
    assign o_outstanding = waiting;
    assign o_xlates      = xlate_count;
    assign o_faults      = fault_count;
    assign o_misses      = miss_count;

    function automatic int unsigned access_bytes(t_class cls);
        case (cls)
            CLS_4B:  return 4;
            CLS_8B:  return 8;
            CLS_16B: return 16;
            default: return 0;
        endcase
    endfunction

    // updates the table for a write, returns the response the request should get
    function automatic t_xlate apply_request(t_cmd c);
        t_xlate      r;
        logic [31:0] div;
        int          hit;
        r        = '0;
        r.status = ST_OK;
        if (c.op == OP_WRITE) begin
            seg_used[c.slot] = c.entry_valid;
            seg_id[c.slot]   = c.id;
            seg_base[c.slot] = c.base;
            seg_len[c.slot]  = c.size;
            return r;
        end
        xlate_count++;
        div       = (seg_divisor == '0) ? 32'd1 : 32'(seg_divisor);
        r.seg_num = c.addr / div;
        r.offset  = OFFSET_BITS'(c.addr % div);
        hit       = -1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (hit < 0 && seg_used[i] && {16'b0, seg_id[i]} == r.seg_num)
                hit = i;
        end
        if (hit < 0) begin
            r.status = ST_NOSEG;
            miss_count++;
            return r;
        end
        r.phys = seg_base[hit] + 32'(r.offset);
        if (c.cls != CLS_UNCHECKED &&
            32'(r.offset) + access_bytes(c.cls) > 32'(seg_len[hit])) begin
            r.status = ST_BOUNDS;
            fault_count++;
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    initial begin
        fail_count  = 0;
        waiting     = 0;
        xlate_count = 0;
        fault_count = 0;
        miss_count  = 0;
    end

    always @(posedge i_clk) begin
        t_cmd   c;
        t_xlate want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                seg_used[i] = 1'b0;
            seg_divisor = MAX_SIZE_RESET;
            pending_xlates.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_xlates.size() == 0) begin
                    fail_count++;
                    $display("%0t: response with nothing expected: phys=%h num=%h off=%h st=%0d",
                             $time, i_rsp.physical_address, i_rsp.segment_number,
                             i_rsp.segment_offset, i_rsp.status);
                end else begin
                    want = pending_xlates.pop_front();
                    compare_field("physical_address", want.phys, i_rsp.physical_address);
                    compare_field("segment_number", want.seg_num, i_rsp.segment_number);
                    compare_field("segment_offset", 32'(want.offset),
                                  32'(i_rsp.segment_offset));
                    compare_field("status", 32'(want.status), 32'(i_rsp.status));
                end
            end
            if (i_cfg.valid && i_cfg.ready)
                seg_divisor = i_cfg.data;
            if (i_req.valid && i_req.ready) begin
                c.op          = t_op'(i_req.kind);
                c.slot        = i_req.entry_slot;
                c.entry_valid = i_req.entry_valid;
                c.id          = i_req.entry_segment_id;
                c.base        = i_req.entry_base;
                c.size        = i_req.entry_size;
                c.addr        = i_req.logical_address;
                c.cls         = t_class'(i_req.access_class);
                pending_xlates.push_back(apply_request(c));
            end
        end
        waiting = pending_xlates.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives table writes, translations and segment size changes into the
// segment address translator with random gaps and response stalls; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
    import sat_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int PHASES       = 8;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk;
    logic i_rst_n;

    sat_req_if req_bus ();
    sat_rsp_if rsp_bus ();
    sat_cfg_if cfg_bus ();

    int fail_count;
    int outstanding;
    int xlates;
    int faults;
    int misses;
    int requests_sent;
    bit no_idle;

    // what the stimulus last wrote, only used to aim translations at segments
    logic [ID_BITS-1:0]      known_id   [TABLE_SLOTS];
    logic [SIZE_BITS-1:0]    known_len  [TABLE_SLOTS];
    logic [DIVISOR_BITS-1:0] cur_divisor;

    segment_address_translator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    segment_address_translator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .i_rsp         (rsp_bus),
        .i_cfg         (cfg_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_xlates      (xlates),
        .o_faults      (faults),
        .o_misses      (misses)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int pick_gap();
        return no_idle ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic t_cmd noise_request();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return t_cmd'(bits[$bits(t_cmd)-1:0]);
    endfunction

    function automatic t_cmd make_write(int slot, bit valid, logic [ID_BITS-1:0] id,
                                        logic [BASE_BITS-1:0] base,
                                        logic [SIZE_BITS-1:0] size);
        t_cmd c;
        c             = noise_request();
        c.op          = OP_WRITE;
        c.slot        = SLOT_FIELD_BITS'(slot);
        c.entry_valid = valid;
        c.id          = id;
        c.base        = base;
        c.size        = size;
        return c;
    endfunction

    function automatic t_cmd make_xlate(logic [LA_BITS-1:0] addr, t_class cls);
        t_cmd c;
        c      = noise_request();
        c.op   = OP_XLATE;
        c.addr = addr;
        c.cls  = cls;
        return c;
    endfunction

    // mostly writes and translations aimed at stored segments, some noise
    function automatic t_cmd random_request();
        t_cmd        c;
        int unsigned pick;
        int unsigned slot;
        int          width;
        int          target;
        logic [63:0] div;
        logic [63:0] addr;
        c    = noise_request();
        pick = $urandom_range(0, 99);
        div  = (cur_divisor == '0) ? 64'd1 : 64'(cur_divisor);
        if (pick < 35) begin
            c.op          = OP_WRITE;
            c.entry_valid = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 1) == 1)
                c.size = SIZE_BITS'($urandom_range(0, 40));
            // a few repeated ids so that the first match matters
            if ($urandom_range(0, 3) == 0)
                c.id = ID_BITS'($urandom_range(0, 3));
        end else if (pick < 88) begin
            c.op  = OP_XLATE;
            slot  = $urandom_range(0, TABLE_SLOTS - 1);
            width = (c.cls == CLS_UNCHECKED) ? 0 : (4 << c.cls);
            if ($urandom_range(0, 1) == 1) begin
                // land right around the end of the segment
                target = int'(known_len[slot]) - width + int'($urandom_range(0, 2)) - 1;
                if (target < 0)
                    target = 0;
                if (64'(target) >= div)
                    target = int'(div) - 1;
            end else begin
                target = int'(64'($urandom) % div);
            end
            addr   = 64'(known_id[slot]) * div + 64'(target);
            c.addr = addr[LA_BITS-1:0];
        end
        return c;
    endfunction

    task automatic send_request(t_cmd c);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid            <= 1'b1;
        req_bus.kind             <= c.op;
        req_bus.entry_slot       <= c.slot;
        req_bus.entry_valid      <= c.entry_valid;
        req_bus.entry_segment_id <= c.id;
        req_bus.entry_base       <= c.base;
        req_bus.entry_size       <= c.size;
        req_bus.logical_address  <= c.addr;
        req_bus.access_class     <= c.cls;
        if (c.op == OP_WRITE) begin
            known_id[c.slot]   = c.id;
            known_len[c.slot]  = c.size;
        end
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_divisor(logic [DIVISOR_BITS-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        cur_divisor = value;
    endtask

    // response side: random stalls, plus two long hold-offs mid-run
    initial begin
        int gap;
        int taken;
        rsp_bus.ready = 1'b0;
        taken = 0;
        forever begin
            gap = (taken == 200 || taken == 600) ? HOLD_CYCLES : pick_gap();
            @(negedge i_clk);
            if (gap > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_bus.valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin
        logic [DIVISOR_BITS-1:0] next_div;
        i_rst_n                  = 1'b0;
        req_bus.valid            = 1'b0;
        req_bus.kind             = OP_WRITE;
        req_bus.entry_slot       = '0;
        req_bus.entry_valid      = 1'b0;
        req_bus.entry_segment_id = '0;
        req_bus.entry_base       = '0;
        req_bus.entry_size       = '0;
        req_bus.logical_address  = '0;
        req_bus.access_class     = CLS_4B;
        cfg_bus.valid            = 1'b0;
        cfg_bus.data             = '0;
        no_idle                  = 1'b0;
        requests_sent            = 0;
        cur_divisor              = MAX_SIZE_RESET;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            known_id[i]   = '0;
            known_len[i]  = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table after reset, segment size 64
        send_request(make_xlate(32'h0, CLS_4B));
        send_request(make_write(0, 1'b1, 16'h0, 32'h0000_1000, 16'd64));
        send_request(make_xlate(32'd60, CLS_4B));
        send_request(make_xlate(32'd61, CLS_4B));
        send_request(make_xlate(32'd56, CLS_8B));
        send_request(make_xlate(32'd57, CLS_8B));
        send_request(make_xlate(32'd48, CLS_16B));
        send_request(make_xlate(32'd49, CLS_16B));
        send_request(make_xlate(32'd63, CLS_UNCHECKED));
        send_request(make_write(15, 1'b1, 16'd3, 32'hFFFF_FFF0, 16'hFFFF));
        // base plus offset wraps past the top of the address space
        send_request(make_xlate(32'd3 * 64 + 63, CLS_UNCHECKED));
        // same id in a lower slot wins, and its zero length faults
        send_request(make_write(5, 1'b1, 16'd3, 32'h0000_2000, 16'd0));
        send_request(make_xlate(32'd3 * 64, CLS_4B));
        send_request(make_write(5, 1'b0, 16'd3, 32'h0000_0000, 16'd0));
        send_request(make_xlate(32'd3 * 64 + 1, CLS_16B));
        // segment number wider than any id
        send_request(make_xlate(32'hFFFF_FFFF, CLS_4B));
        send_request(make_write(1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_request(make_xlate(32'hFFFF * 64 + 5, CLS_16B));
        send_request(make_xlate(32'h0000_0040, CLS_4B));

        // a zero segment size divides by one
        drain_requests();
        write_divisor(16'h0000);
        send_request(make_xlate(32'd3, CLS_UNCHECKED));
        send_request(make_xlate(32'd65535, CLS_8B));

        drain_requests();
        write_divisor(16'hFFFF);
        send_request(make_xlate(32'hFFFF_FFFF, CLS_4B));
        send_request(make_xlate(32'hFFFE_FFFF, CLS_4B));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       next_div = 16'd1;
                1:       next_div = 16'd64;
                2:       next_div = DIVISOR_BITS'($urandom_range(2, 300));
                3:       next_div = 16'hFFFF;
                4:       next_div = 16'd0;
                5:       next_div = DIVISOR_BITS'($urandom_range(1, 65535));
                6:       next_div = 16'd7;
                default: next_div = DIVISOR_BITS'($urandom_range(16, 4096));
            endcase
            drain_requests();
            write_divisor(next_div);
            no_idle = (p == 2);
            repeat (RANDOM_ITEMS / PHASES) send_request(random_request());
        end
        no_idle = 1'b0;

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d of them translations (%0d bounds faults, %0d misses)",
                 requests_sent, xlates, faults, misses);
        $display("segment sizes included 0, 1, 7, 64 and 65535 plus random values");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
